[design/bsd_pkg.sv]
// Shared types and constants for the BMP stream decoder.
package bsd_pkg;

    localparam int MaxWidthDef  = 4096;
    localparam int MaxHeightDef = 4096;

    localparam logic [15:0] BmpSignature  = 16'h4D42;
    localparam logic [31:0] InfoHeaderMin = 32'd40;
    localparam logic [31:0] HeaderBytes   = 32'd54;
    localparam logic [15:0] Bpp24         = 16'd24;
    localparam logic [15:0] Bpp32         = 16'd32;
    localparam logic [7:0]  OpaqueAlpha   = 8'hFF;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_DONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_SIGNATURE = 3'd0,
        ERR_SHORT_HDR = 3'd1,
        ERR_FORMAT    = 3'd2,
        ERR_SIZE      = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_OFFSET    = 3'd5
    } t_err;

    typedef struct packed {
        t_kind       kind;
        t_err        error_code;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last;
    } t_result;

    // Up to two results per byte; the first always goes out first.
    typedef struct packed {
        logic    v0;
        t_result r0;
        logic    v1;
        t_result r1;
    } t_result_pair;

endpackage

[design/bsd_parser.sv]
// Byte parser: header fields, checks, row/pixel tracking; up to two results per byte.
module bsd_parser #(
    parameter int MAX_WIDTH  = bsd_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = bsd_pkg::MaxHeightDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_eof,
    output bsd_pkg::t_result_pair o_res
);

    localparam int WBITS = $clog2(MAX_WIDTH + 1);
    localparam int HBITS = $clog2(MAX_HEIGHT + 1);
    localparam int RBITS = $clog2(4 * MAX_WIDTH + 4);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_SKIP    = 4'b0010,
        PH_PIXELS  = 4'b0100,
        PH_DISCARD = 4'b1000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [31:0]        r_pos, n_pos;
    logic [31:0]        r_fa, n_fa;
    logic [31:0]        r_offset, n_offset;
    logic [31:0]        r_width, n_width;
    logic [31:0]        r_height, n_height;
    logic               r_planes_ok, n_planes_ok;
    logic               r_bpp_ok, n_bpp_ok;
    logic               r_bpp32, n_bpp32;
    logic               r_comp_ok, n_comp_ok;
    logic               r_top_down, n_top_down;
    logic [HBITS-1:0]   r_habs, n_habs;
    logic [RBITS-1:0]   r_data_bytes, n_data_bytes;
    logic [RBITS-1:0]   r_stride, n_stride;
    logic [WBITS-1:0]   r_column, n_column;
    logic [HBITS-1:0]   r_row, n_row;
    logic [1:0]         r_bip, n_bip;
    logic [RBITS-1:0]   r_row_byte, n_row_byte;
    logic [23:0]        r_held, n_held;

    logic [31:0]        fa_next;
    logic [31:0]        habs32;
    logic [WBITS-1:0]   w_short;
    logic [RBITS-1:0]   db;
    logic [RBITS-1:0]   stride_sum;
    logic [23:0]        merged;
    logic [RBITS-1:0]   rb_next;
    logic [HBITS-1:0]   row_next;
    logic               last_byte;
    logic               emit_a;
    bsd_pkg::t_result   res_a;
    logic               fin;
    bsd_pkg::t_result   res_f;
    logic               clear;

    assign fa_next    = {i_byte, r_fa[31:8]};
    assign habs32     = r_height[31] ? (32'd0 - r_height) : r_height;
    assign w_short    = r_width[WBITS-1:0];
    assign db         = r_bpp32 ? (RBITS'(w_short) << 2)
                                : ((RBITS'(w_short) << 1) + RBITS'(w_short));
    assign stride_sum = db + RBITS'(3);
    assign rb_next    = r_row_byte + RBITS'(1);
    assign row_next   = r_row + HBITS'(1);
    assign last_byte  = r_bpp32 ? (r_bip == 2'd3) : (r_bip == 2'd2);

    always_comb begin
        merged = r_held;
        unique case (r_bip)
            2'd0: merged[7:0]   = i_byte;
            2'd1: merged[15:8]  = i_byte;
            2'd2: merged[23:16] = i_byte;
            default: merged = r_held;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_fa         = r_fa;
        n_offset     = r_offset;
        n_width      = r_width;
        n_height     = r_height;
        n_planes_ok  = r_planes_ok;
        n_bpp_ok     = r_bpp_ok;
        n_bpp32      = r_bpp32;
        n_comp_ok    = r_comp_ok;
        n_top_down   = r_top_down;
        n_habs       = r_habs;
        n_data_bytes = r_data_bytes;
        n_stride     = r_stride;
        n_column     = r_column;
        n_row        = r_row;
        n_bip        = r_bip;
        n_row_byte   = r_row_byte;
        n_held       = r_held;
        emit_a       = 1'b0;
        res_a        = '0;
        fin          = 1'b0;
        res_f        = '0;
        res_f.last   = 1'b1;
        clear        = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                n_fa  = fa_next;
                n_pos = r_pos + 32'd1;
                if (r_pos == 32'd13) n_offset = fa_next;
                if (r_pos == 32'd21) n_width = fa_next;
                if (r_pos == 32'd25) n_height = fa_next;
                if (r_pos == 32'd27) n_planes_ok = (fa_next[31:16] == 16'd1);
                if (r_pos == 32'd29) begin
                    n_bpp_ok = (fa_next[31:16] == bsd_pkg::Bpp24) ||
                               (fa_next[31:16] == bsd_pkg::Bpp32);
                    n_bpp32  = (fa_next[31:16] == bsd_pkg::Bpp32);
                end
                if (r_pos == 32'd33) n_comp_ok = (fa_next == 32'd0);

                priority if (r_pos == 32'd1 && fa_next[31:16] != bsd_pkg::BmpSignature) begin
                    fin              = 1'b1;
                    res_f.kind       = bsd_pkg::KIND_ERROR;
                    res_f.error_code = bsd_pkg::ERR_SIGNATURE;
                end else if (r_pos == 32'd17 && fa_next < bsd_pkg::InfoHeaderMin) begin
                    fin              = 1'b1;
                    res_f.kind       = bsd_pkg::KIND_ERROR;
                    res_f.error_code = bsd_pkg::ERR_SHORT_HDR;
                end else if (r_pos == 32'd53) begin
                    priority if (!r_planes_ok || !r_comp_ok || !r_bpp_ok ||
                                 r_width == 32'd0 || r_width[31] ||
                                 r_height == 32'd0) begin
                        fin              = 1'b1;
                        res_f.kind       = bsd_pkg::KIND_ERROR;
                        res_f.error_code = bsd_pkg::ERR_FORMAT;
                    end else if (r_width > 32'(MAX_WIDTH) ||
                                 habs32 > 32'(MAX_HEIGHT)) begin
                        fin              = 1'b1;
                        res_f.kind       = bsd_pkg::KIND_ERROR;
                        res_f.error_code = bsd_pkg::ERR_SIZE;
                    end else if (r_offset < bsd_pkg::HeaderBytes) begin
                        fin              = 1'b1;
                        res_f.kind       = bsd_pkg::KIND_ERROR;
                        res_f.error_code = bsd_pkg::ERR_OFFSET;
                    end else begin
                        emit_a             = 1'b1;
                        res_a.kind         = bsd_pkg::KIND_HEADER;
                        res_a.image_width  = 13'(r_width);
                        res_a.image_height = 13'(habs32);
                        n_top_down   = r_height[31];
                        n_habs       = HBITS'(habs32);
                        n_data_bytes = db;
                        n_stride     = {stride_sum[RBITS-1:2], 2'b00};
                        n_column     = '0;
                        n_row        = '0;
                        n_bip        = '0;
                        n_row_byte   = '0;
                        n_held       = '0;
                        n_phase      = (r_offset == bsd_pkg::HeaderBytes) ? PH_PIXELS
                                                                         : PH_SKIP;
                    end
                end else begin
                    fin = 1'b0;
                end
            end

            PH_SKIP: begin
                n_pos = r_pos + 32'd1;
                if (n_pos == r_offset) n_phase = PH_PIXELS;
            end

            PH_PIXELS: begin
                if (r_row_byte < r_data_bytes) begin
                    if (last_byte) begin
                        emit_a        = 1'b1;
                        res_a.kind    = bsd_pkg::KIND_PIXEL;
                        res_a.pixel_x = 12'(r_column);
                        res_a.pixel_y = r_top_down ? 12'(r_row)
                                                   : 12'(r_habs - HBITS'(1) - r_row);
                        res_a.blue    = merged[7:0];
                        res_a.green   = merged[15:8];
                        res_a.red     = merged[23:16];
                        res_a.alpha   = r_bpp32 ? i_byte : bsd_pkg::OpaqueAlpha;
                        n_column      = r_column + WBITS'(1);
                        n_bip         = '0;
                        n_held        = '0;
                    end else begin
                        n_bip  = r_bip + 2'd1;
                        n_held = merged;
                    end
                end
                n_row_byte = rb_next;
                if (rb_next >= r_stride) begin
                    n_row_byte = '0;
                    n_column   = '0;
                    n_bip      = '0;
                    n_held     = '0;
                    n_row      = row_next;
                    if (row_next >= r_habs) begin
                        fin        = 1'b1;
                        res_f.kind = bsd_pkg::KIND_DONE;
                    end
                end
            end

            PH_DISCARD: begin
                if (i_eof) clear = 1'b1;
            end

            default: begin
                clear = 1'b1;
            end
        endcase

        // end of file before the image completes
        if (!fin && i_eof && r_phase != PH_DISCARD) begin
            fin              = 1'b1;
            res_f.kind       = bsd_pkg::KIND_ERROR;
            res_f.error_code = bsd_pkg::ERR_TRUNCATED;
        end

        if (fin) begin
            if (i_eof) clear = 1'b1;
            else       n_phase = PH_DISCARD;
        end

        if (clear) begin
            n_phase      = PH_HEADER;
            n_pos        = '0;
            n_fa         = '0;
            n_offset     = '0;
            n_width      = '0;
            n_height     = '0;
            n_planes_ok  = 1'b0;
            n_bpp_ok     = 1'b0;
            n_bpp32      = 1'b0;
            n_comp_ok    = 1'b0;
            n_top_down   = 1'b0;
            n_habs       = '0;
            n_data_bytes = '0;
            n_stride     = '0;
            n_column     = '0;
            n_row        = '0;
            n_bip        = '0;
            n_row_byte   = '0;
            n_held       = '0;
        end
    end

    always_comb begin
        o_res = '0;
        if (i_step) begin
            if (emit_a) begin
                o_res.v0 = 1'b1;
                o_res.r0 = res_a;
                o_res.v1 = fin;
                o_res.r1 = res_f;
            end else begin
                o_res.v0 = fin;
                o_res.r0 = res_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_fa         <= '0;
            r_offset     <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_planes_ok  <= 1'b0;
            r_bpp_ok     <= 1'b0;
            r_bpp32      <= 1'b0;
            r_comp_ok    <= 1'b0;
            r_top_down   <= 1'b0;
            r_habs       <= '0;
            r_data_bytes <= '0;
            r_stride     <= '0;
            r_column     <= '0;
            r_row        <= '0;
            r_bip        <= '0;
            r_row_byte   <= '0;
            r_held       <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_fa         <= n_fa;
            r_offset     <= n_offset;
            r_width      <= n_width;
            r_height     <= n_height;
            r_planes_ok  <= n_planes_ok;
            r_bpp_ok     <= n_bpp_ok;
            r_bpp32      <= n_bpp32;
            r_comp_ok    <= n_comp_ok;
            r_top_down   <= n_top_down;
            r_habs       <= n_habs;
            r_data_bytes <= n_data_bytes;
            r_stride     <= n_stride;
            r_column     <= n_column;
            r_row        <= n_row;
            r_bip        <= n_bip;
            r_row_byte   <= n_row_byte;
            r_held       <= n_held;
        end
    end

endmodule

[design/bsd_out_fifo.sv]
// Four-entry result queue taking up to two results per cycle.
module bsd_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bsd_pkg::t_result_pair i_push,
    input  logic                  i_pop_ready,
    output logic                  o_valid,
    output bsd_pkg::t_result      o_head,
    output logic                  o_space
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    bsd_pkg::t_result  r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PtrW:0]     r_count, n_count;
    logic              pop;
    logic [PtrW:0]     push_cnt;

    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    // room for a worst-case pair of results
    assign o_space  = (r_count <= (PtrW+1)'(Depth - 2));
    assign pop      = o_valid && i_pop_ready;
    assign push_cnt = (PtrW+1)'(i_push.v0) + (PtrW+1)'(i_push.v1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PtrW'(push_cnt);
        n_rd_ptr = r_rd_ptr + PtrW'(pop);
        n_count  = r_count + push_cnt - (PtrW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr_ptr] <= i_push.r0;
        if (i_push.v1) r_mem[r_wr_ptr + PtrW'(1)] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[design/bmp_stream_decoder_unit.sv]
// Top level of the BMP stream decoder: input register, parser, result queue.
// Decodes an uncompressed 24- or 32-bit BMP file arriving one byte per beat and
// emits a header beat, one beat per pixel (RGBA plus destination x/y, y flipped
// for bottom-up files), and a done or error beat marked with tlast. A byte is
// taken every cycle while the queue has room; each accepted byte waits in the input
// register, is parsed, and its results are written into the queue and offered from there.
// Most bytes give zero or one result, a few give two (a result plus
// done or an error), so results go through a four-entry queue and the input
// stalls only while that queue has fewer than two free entries. After done or
// an error, bytes are dropped up to the beat with tlast; the next beat starts a
// new file.
module bmp_stream_decoder_unit #(
    parameter int MAX_WIDTH  = bsd_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = bsd_pkg::MaxHeightDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // end_of_file
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // error_code[2:0], pixel_x[14:3], pixel_y[26:15], red[34:27], green[42:35],
    // blue[50:43], alpha[58:51], image_width[71:59], image_height[84:72], zeros
    output logic [87:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast    // last
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eof;
    logic                  step;
    logic                  space;
    logic                  in_beat;
    bsd_pkg::t_result_pair res_pair;
    bsd_pkg::t_result      head;

    assign step            = r_in_valid && space;
    assign o_s_axis_tready = !r_in_valid || step;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eof  <= i_s_axis_tlast;
        end
    end

    bsd_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .o_res   (res_pair)
    );

    bsd_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_pair),
        .i_pop_ready (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_head      (head),
        .o_space     (space)
    );

    assign o_m_axis_tdata = {3'b000, head.image_height, head.image_width, head.alpha,
                             head.blue, head.green, head.red, head.pixel_y,
                             head.pixel_x, head.error_code};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

[dv/bmp_stream_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the BMP stream decoder: random BMP files in, checked beats out.
module bmp_stream_decoder_unit_tb;

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_SKIP,
        PARSE_PIXELS,
        PARSE_DISCARD
    } t_parse_phase;

    typedef enum int {
        SC_GOOD,
        SC_TRUNC,
        SC_SIG,
        SC_SHORT,
        SC_FORMAT,
        SC_SIZE,
        SC_OFFSET,
        SC_NOISE
    } t_file_kind;

    typedef enum int {
        CUT_NONE,
        CUT_IN_HEADER,
        CUT_AT_HEADER_END,
        CUT_IN_BODY
    } t_cut_mode;

    typedef struct {
        logic [7:0] data;
        logic       eof;
        bit         wait_drain;
    } t_file_beat;

    // error_code reads zero on beats that are not errors
    localparam bsd_pkg::t_err NoError = bsd_pkg::ERR_SIGNATURE;
    localparam int IdlePct       = 32;
    localparam int ItemTarget    = 1700;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 20;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'd0;   // data_byte
    logic        i_s_axis_tlast  = 1'b0;   // end_of_file
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // error_code, pixel_x, pixel_y, red, green, blue, alpha, image_width, image_height, zeros
    logic [87:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;           // kind
    logic        o_m_axis_tlast;           // last

    t_file_beat       file_beats[$];
    bsd_pkg::t_result expected_beats[$];

    int  cycle_count    = 0;
    int  bytes_accepted = 0;
    int  stim_bytes     = 0;
    int  files_built    = 0;
    int  mismatches     = 0;
    int  beats_checked  = 0;
    int  kind_seen[4]   = '{0, 0, 0, 0};
    logic rx_hold       = 1'b0;
    wire steady = (cycle_count >= 200) && (cycle_count < 700);

    // decoder state mirror
    t_parse_phase pr_phase;
    logic [31:0]  pr_pos, pr_shift, pr_offset, pr_hsize, pr_width, pr_height, pr_comp;
    logic [15:0]  pr_planes, pr_bpp;
    logic         pr_top_down;
    logic [31:0]  pr_col, pr_row, pr_bip, pr_row_byte, pr_held;

    bmp_stream_decoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic restart_file();
        pr_phase    = PARSE_HEADER;
        pr_pos      = '0;
        pr_shift    = '0;
        pr_offset   = '0;
        pr_hsize    = '0;
        pr_width    = '0;
        pr_height   = '0;
        pr_planes   = '0;
        pr_bpp      = '0;
        pr_comp     = '0;
        pr_top_down = 1'b0;
        pr_col      = '0;
        pr_row      = '0;
        pr_bip      = '0;
        pr_row_byte = '0;
        pr_held     = '0;
    endtask

    function automatic bsd_pkg::t_result make_result(input bsd_pkg::t_kind k,
                                                     input bsd_pkg::t_err e, input logic fin);
        bsd_pkg::t_result r;
        r = '0;
        r.kind       = k;
        r.error_code = e;
        r.last       = fin;
        return r;
    endfunction

    task automatic close_file(input bsd_pkg::t_kind k, input bsd_pkg::t_err e, input logic eof);
        expected_beats.push_back(make_result(k, e, 1'b1));
        if (eof) restart_file();
        else pr_phase = PARSE_DISCARD;
    endtask

    // Expected beats for one accepted byte.
    task automatic decode_byte(input logic [7:0] b, input logic eof);
        logic [31:0] pos, abs_h, pix_bytes, row_bytes, stride, y;
        bsd_pkg::t_result r;
        abs_h = pr_height[31] ? -pr_height : pr_height;
        case (pr_phase)
            PARSE_HEADER: begin
                pos      = pr_pos;
                pr_shift = {b, pr_shift[31:8]};
                pr_pos   = pos + 1;
                if (pos == 1 && pr_shift[31:16] != bsd_pkg::BmpSignature) begin
                    close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_SIGNATURE, eof);
                    return;
                end
                // little-endian fields complete on their last byte
                case (pos)
                    13: pr_offset = pr_shift;
                    17: pr_hsize  = pr_shift;
                    21: pr_width  = pr_shift;
                    25: pr_height = pr_shift;
                    27: pr_planes = pr_shift[31:16];
                    29: pr_bpp    = pr_shift[31:16];
                    33: pr_comp   = pr_shift;
                    default: ;
                endcase
                if (pos == 17 && pr_hsize < bsd_pkg::InfoHeaderMin) begin
                    close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_SHORT_HDR, eof);
                    return;
                end
                if (pos == 53) begin
                    abs_h = pr_height[31] ? -pr_height : pr_height;
                    if (pr_planes != 16'd1 || pr_comp != 32'd0
                        || (pr_bpp != bsd_pkg::Bpp24 && pr_bpp != bsd_pkg::Bpp32)
                        || pr_width == 32'd0 || pr_width[31] || pr_height == 32'd0) begin
                        close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_FORMAT, eof);
                        return;
                    end
                    if (pr_width > 32'(bsd_pkg::MaxWidthDef)
                        || abs_h > 32'(bsd_pkg::MaxHeightDef)) begin
                        close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_SIZE, eof);
                        return;
                    end
                    if (pr_offset < bsd_pkg::HeaderBytes) begin
                        close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_OFFSET, eof);
                        return;
                    end
                    r = make_result(bsd_pkg::KIND_HEADER, NoError, 1'b0);
                    r.image_width  = pr_width[12:0];
                    r.image_height = abs_h[12:0];
                    expected_beats.push_back(r);
                    pr_top_down = pr_height[31];
                    pr_col      = '0;
                    pr_row      = '0;
                    pr_bip      = '0;
                    pr_row_byte = '0;
                    pr_held     = '0;
                    pr_phase    = (pr_offset == bsd_pkg::HeaderBytes) ? PARSE_PIXELS
                                                                      : PARSE_SKIP;
                end
                if (eof) close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_TRUNCATED, 1'b1);
            end
            PARSE_SKIP: begin
                pr_pos = pr_pos + 1;
                if (pr_pos == pr_offset) pr_phase = PARSE_PIXELS;
                if (eof) close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_TRUNCATED, 1'b1);
            end
            PARSE_PIXELS: begin
                pix_bytes = {16'd0, pr_bpp} >> 3;
                row_bytes = pr_width * pix_bytes;
                stride    = (row_bytes + 32'd3) & ~32'd3;
                if (pr_row_byte < row_bytes) begin
                    pr_held = pr_held | ({24'd0, b} << (8 * pr_bip[1:0]));
                    if (pr_bip + 1 >= pix_bytes) begin
                        r = make_result(bsd_pkg::KIND_PIXEL, NoError, 1'b0);
                        y = pr_top_down ? pr_row : abs_h - 32'd1 - pr_row;
                        r.pixel_x = pr_col[11:0];
                        r.pixel_y = y[11:0];
                        r.blue    = pr_held[7:0];
                        r.green   = pr_held[15:8];
                        r.red     = pr_held[23:16];
                        r.alpha   = (pix_bytes == 32'd4) ? b : bsd_pkg::OpaqueAlpha;
                        expected_beats.push_back(r);
                        pr_col  = pr_col + 1;
                        pr_bip  = '0;
                        pr_held = '0;
                    end else begin
                        pr_bip = pr_bip + 1;
                    end
                end
                pr_row_byte = pr_row_byte + 1;
                if (pr_row_byte >= stride) begin
                    pr_row_byte = '0;
                    pr_col      = '0;
                    pr_bip      = '0;
                    pr_held     = '0;
                    pr_row      = pr_row + 1;
                    if (pr_row >= abs_h) begin
                        close_file(bsd_pkg::KIND_DONE, NoError, eof);
                        return;
                    end
                end
                if (eof) close_file(bsd_pkg::KIND_ERROR, bsd_pkg::ERR_TRUNCATED, 1'b1);
            end
            default: begin
                if (eof) restart_file();
            end
        endcase
    endtask

    task automatic add_beat(input logic [7:0] d, input logic eof, input bit wait_drain);
        t_file_beat fb;
        fb.data       = d;
        fb.eof        = eof;
        fb.wait_drain = wait_drain;
        file_beats.push_back(fb);
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) add_beat(8'($urandom_range(255)), i == n - 1, 1'b0);
    endtask

    task automatic add_file(input logic [15:0] sig, input logic [31:0] offset, hsize, width,
                            height, input logic [15:0] planes, bpp, input logic [31:0] comp,
                            input t_cut_mode cut, input int extra, input bit wait_drain);
        logic [7:0]  hdr [54];
        logic [31:0] abs_h, stride;
        int gap, body, len;
        abs_h = height[31] ? -height : height;
        gap   = (offset > bsd_pkg::HeaderBytes) ? int'(offset - bsd_pkg::HeaderBytes) : 0;
        body  = 0;
        if (width >= 1 && width <= bsd_pkg::MaxWidthDef
            && abs_h >= 1 && abs_h <= bsd_pkg::MaxHeightDef
            && (bpp == bsd_pkg::Bpp24 || bpp == bsd_pkg::Bpp32)) begin
            stride = (width * (bpp >> 3) + 32'd3) & ~32'd3;
            if (stride * abs_h <= 40000) body = stride * abs_h;
        end
        // a rejected header still gets a few bytes so the drop path runs
        if (body == 0) body = 3;
        len = bsd_pkg::HeaderBytes + gap + body;
        case (cut)
            CUT_IN_HEADER:     len = $urandom_range(53, 1);
            CUT_AT_HEADER_END: len = bsd_pkg::HeaderBytes;
            CUT_IN_BODY:       len = $urandom_range(len - 1, bsd_pkg::HeaderBytes + 1);
            default: ;
        endcase
        foreach (hdr[i]) hdr[i] = 8'($urandom_range(255));
        for (int k = 0; k < 4; k++) begin
            if (k < 2) begin
                hdr[k]      = sig[8*k +: 8];
                hdr[26 + k] = planes[8*k +: 8];
                hdr[28 + k] = bpp[8*k +: 8];
            end
            hdr[10 + k] = offset[8*k +: 8];
            hdr[14 + k] = hsize[8*k +: 8];
            hdr[18 + k] = width[8*k +: 8];
            hdr[22 + k] = height[8*k +: 8];
            hdr[30 + k] = comp[8*k +: 8];
        end
        for (int i = 0; i < len; i++) begin
            add_beat((i < 54) ? hdr[i] : 8'($urandom_range(255)),
                     (i == len - 1) && (extra == 0 || cut != CUT_NONE),
                     (i == 0) && wait_drain);
        end
        if (cut == CUT_NONE) add_noise(extra);
        stim_bytes += len;
        files_built++;
    endtask

    function automatic int sub_count(input t_file_kind fk);
        case (fk)
            SC_GOOD:   return 4;
            SC_TRUNC:  return 3;
            SC_FORMAT: return 6;
            SC_SIZE:   return 4;
            default:   return 1;
        endcase
    endfunction

    task automatic add_random_file(input t_file_kind fk, input int sub);
        logic [15:0] sig, planes, bpp;
        logic [31:0] offset, hsize, width, height, comp;
        t_cut_mode cut;
        int extra;
        sig    = bsd_pkg::BmpSignature;
        planes = 16'd1;
        comp   = 32'd0;
        bpp    = ($urandom_range(1) != 0) ? bsd_pkg::Bpp32 : bsd_pkg::Bpp24;
        hsize  = ($urandom_range(3) == 0) ? 32'($urandom_range(124, 41))
                                          : bsd_pkg::InfoHeaderMin;
        if ($urandom_range(9) == 0) hsize = 32'hFFFF_FFFF;
        width  = $urandom_range(6, 1);
        height = $urandom_range(4, 1);
        if ($urandom_range(1) != 0) height = -height;
        offset = ($urandom_range(2) == 0) ? bsd_pkg::HeaderBytes + $urandom_range(8, 1)
                                          : bsd_pkg::HeaderBytes;
        cut    = CUT_NONE;
        extra  = ($urandom_range(1) != 0) ? $urandom_range(3, 1) : 0;
        case (fk)
            SC_GOOD: begin
                // sub picks depth and row order so the first pass hits all four
                bpp    = sub[0] ? bsd_pkg::Bpp32 : bsd_pkg::Bpp24;
                height = sub[1] ? -32'($urandom_range(4, 1)) : 32'($urandom_range(4, 1));
            end
            SC_TRUNC: begin
                cut = (sub == 0) ? CUT_IN_HEADER : (sub == 1) ? CUT_AT_HEADER_END : CUT_IN_BODY;
            end
            SC_SIG: begin
                sig = 16'($urandom);
                if (sig == bsd_pkg::BmpSignature) sig[0] = ~sig[0];
            end
            SC_SHORT: hsize = $urandom_range(39, 0);
            SC_FORMAT: begin
                case (sub)
                    0: begin
                        planes = 16'($urandom);
                        if (planes == 16'd1) planes = 16'd0;
                    end
                    1: comp = ($urandom_range(1) != 0) ? 32'($urandom_range(6, 1))
                                                       : 32'h8000_0000 | $urandom;
                    2: begin
                        bpp = ($urandom_range(1) != 0) ? 16'($urandom_range(64)) : 16'($urandom);
                        if (bpp == bsd_pkg::Bpp24 || bpp == bsd_pkg::Bpp32) bpp = 16'd16;
                    end
                    3: width = 32'd0;
                    4: width = 32'h8000_0000 | $urandom;
                    default: height = 32'd0;
                endcase
            end
            SC_SIZE: begin
                // offset may be bad too; size is reported first
                offset = $urandom_range(62, 0);
                case (sub)
                    0: width = ($urandom_range(1) != 0) ? 32'(bsd_pkg::MaxWidthDef + 1)
                                : 32'($urandom_range(32'h7FFF_FFFF, bsd_pkg::MaxWidthDef + 1));
                    1: height = 32'(bsd_pkg::MaxHeightDef + 1 + $urandom_range(3));
                    2: height = -32'(bsd_pkg::MaxHeightDef + 1 + $urandom_range(3));
                    default: height = 32'h8000_0000;
                endcase
            end
            SC_OFFSET: offset = $urandom_range(53, 0);
            default: ;
        endcase
        add_file(sig, offset, hsize, width, height, planes, bpp, comp, cut, extra,
                 $urandom_range(5) == 0);
    endtask

    // sender: one byte per beat from file_beats, prediction on each accepted beat
    always @(posedge i_clk) begin : drive_bytes
        bit busy;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            busy = i_s_axis_tvalid && !o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_byte(i_s_axis_tdata, i_s_axis_tlast);
                bytes_accepted++;
            end
            if (!busy) begin
                if (file_beats.size() != 0
                    && !(file_beats[0].wait_drain && expected_beats.size() != 0)
                    && (steady || $urandom_range(99) >= IdlePct)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= file_beats[0].data;
                    i_s_axis_tlast  <= file_beats[0].eof;
                    void'(file_beats.pop_front());
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                      beats_checked, name, got, want));
    endtask

    // receiver: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : watch_results
        bsd_pkg::t_result got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind         = bsd_pkg::t_kind'(o_m_axis_tuser);
                got.error_code   = bsd_pkg::t_err'(o_m_axis_tdata[2:0]);
                got.pixel_x      = o_m_axis_tdata[14:3];
                got.pixel_y      = o_m_axis_tdata[26:15];
                got.red          = o_m_axis_tdata[34:27];
                got.green        = o_m_axis_tdata[42:35];
                got.blue         = o_m_axis_tdata[50:43];
                got.alpha        = o_m_axis_tdata[58:51];
                got.image_width  = o_m_axis_tdata[71:59];
                got.image_height = o_m_axis_tdata[84:72];
                got.last         = o_m_axis_tlast;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, kind %0d", o_m_axis_tuser));
                end else begin
                    want = expected_beats.pop_front();
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("error_code", 32'(got.error_code), 32'(want.error_code));
                    check_field("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
                    check_field("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
                    check_field("red", 32'(got.red), 32'(want.red));
                    check_field("green", 32'(got.green), 32'(want.green));
                    check_field("blue", 32'(got.blue), 32'(want.blue));
                    check_field("alpha", 32'(got.alpha), 32'(want.alpha));
                    check_field("image_width", 32'(got.image_width), 32'(want.image_width));
                    check_field("image_height", 32'(got.image_height),
                                32'(want.image_height));
                    check_field("last", 32'(got.last), 32'(want.last));
                    kind_seen[want.kind]++;
                end
                beats_checked++;
            end
            i_m_axis_tready <= !rx_hold && (steady || $urandom_range(99) >= IdlePct);
        end
    end

    // long receiver stall so the result queue fills and the input backs up
    initial begin : receiver_hold_off
        wait (bytes_accepted >= 700);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout: decoder stopped making progress");
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_file_kind fk;
        int w;
        restart_file();

        // short runs: eof on the first byte, eof right after a good signature,
        // bad signature followed by dropped bytes, bad signature on the final byte
        add_beat(8'h00, 1'b1, 1'b0);
        add_beat(8'h42, 1'b0, 1'b0);
        add_beat(8'h4D, 1'b1, 1'b0);
        add_beat(8'h42, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b0);
        add_beat(8'hFF, 1'b0, 1'b0);
        add_beat(8'h80, 1'b1, 1'b0);
        add_beat(8'hFF, 1'b0, 1'b0);
        add_beat(8'h4D, 1'b1, 1'b0);

        // one pass through every file shape, then weighted random files
        for (int k = SC_GOOD; k <= SC_NOISE; k++) begin
            fk = t_file_kind'(k);
            for (int s = 0; s < sub_count(fk); s++) begin
                if (fk == SC_NOISE) add_noise($urandom_range(12, 1));
                else add_random_file(fk, s);
            end
        end

        while (stim_bytes < ItemTarget) begin
            w = $urandom_range(99);
            if (w < 50) fk = SC_GOOD;
            else if (w < 64) fk = SC_TRUNC;
            else if (w < 69) fk = SC_SIG;
            else if (w < 74) fk = SC_SHORT;
            else if (w < 84) fk = SC_FORMAT;
            else if (w < 91) fk = SC_SIZE;
            else if (w < 96) fk = SC_OFFSET;
            else fk = SC_NOISE;
            if (fk == SC_NOISE) begin
                add_noise($urandom_range(12, 1));
                stim_bytes += 6;
            end else begin
                add_random_file(fk, $urandom_range(sub_count(fk) - 1));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (file_beats.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));
        $display("Sent %0d files (%0d bytes): good, truncated and malformed images, noise,",
                 files_built, bytes_accepted);
        $display("checked %0d beats: %0d pixel, %0d header, %0d error, %0d done.",
                 beats_checked, kind_seen[bsd_pkg::KIND_PIXEL], kind_seen[bsd_pkg::KIND_HEADER],
                 kind_seen[bsd_pkg::KIND_ERROR], kind_seen[bsd_pkg::KIND_DONE]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
